[src/rtf_pkg.sv]
package rtf_pkg;

  localparam int PAGE_W = 20;
  localparam int END_W  = 21;
  localparam int ACT_W  = 3;
  localparam int STAT_W = 3;

  localparam logic [ACT_W-1:0] ACT_ALLOC  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_FIXED  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_UNMAP  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_FAULT  = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOSPACE  = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_FATAL    = 3'd4;

  typedef struct packed {
    logic [PAGE_W-1:0] start;
    logic [PAGE_W-1:0] length;
    logic              wr;
    logic              gd;
  } rtf_entry_t;

endpackage

[src/rtf_ifs.sv]
interface rtf_req_if import rtf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [PAGE_W-1:0] page;
  logic [PAGE_W-1:0] length_pages;
  logic              writable;
  logic              grows_down;

  modport source (output valid, action, page, length_pages, writable, grows_down,
                  input ready);
  modport sink (input valid, action, page, length_pages, writable, grows_down,
                output ready);
endinterface

interface rtf_rsp_if import rtf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [PAGE_W-1:0] result_page;
  logic              result_writable;
  logic [PAGE_W-1:0] freed_pages;

  modport source (output valid, status, result_page, result_writable, freed_pages,
                  input ready);
  modport sink (input valid, status, result_page, result_writable, freed_pages,
                output ready);
endinterface

[src/rtf_ram.sv]
module rtf_ram import rtf_pkg::*; #(
  parameter int Depth = 16,
  parameter int AddrW = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  rtf_entry_t       wdata,
  input  logic [AddrW-1:0] raddr,
  output rtf_entry_t       rdata
);

  rtf_entry_t mem [Depth];
  rtf_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[src/region_table_first_fit.sv]
// Region table, one request at a time; a new request is taken while a result waits.
// A request may walk the table memory (one entry read per cycle) and shift entries on
// insert, split or drop; a finished result waits in S_DONE while the output register is
// still held by a stalled output. The next request is taken as the result appears.
// Reset (synchronous): region count and control clear; table contents are not cleared.
module region_table_first_fit import rtf_pkg::*; #(
  parameter int MAX_REGIONS   = 16,
  parameter int USER_END_PAGE = 786432
) (
  input logic       clk,
  input logic       rst_n,
  rtf_req_if.sink   in_req,
  rtf_rsp_if.source out_rsp
);

  localparam int AW = $clog2(MAX_REGIONS);
  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam logic [END_W-1:0] UEND = END_W'(USER_END_PAGE);
  localparam logic [CW-1:0]    MAXC = CW'(MAX_REGIONS);
  localparam logic [CW-1:0]    ONE  = CW'(1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_POS   = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_FIN2  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [ACT_W-1:0]  act_r, act_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic [PAGE_W-1:0] len_r, len_nxt;
  logic              wr_r, wr_nxt;
  logic              gd_r, gd_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     iss_r, iss_nxt;
  logic              rv_r, rv_nxt;
  logic [CW-1:0]     ridx_r, ridx_nxt;
  logic [END_W-1:0]  prev_end_r, prev_end_nxt;
  logic [PAGE_W-1:0] at_r, at_nxt;
  logic [CW-1:0]     rem_r, rem_nxt;
  logic              dn_r, dn_nxt;
  logic              fin_r, fin_nxt;
  logic              two_r, two_nxt;
  logic              inc_r, inc_nxt;
  logic              dec_r, dec_nxt;
  logic [CW-1:0]     fa_r, fa_nxt;
  rtf_entry_t        fw0_r, fw0_nxt;
  rtf_entry_t        fw1_r, fw1_nxt;
  logic [STAT_W-1:0] st_r, st_nxt;
  logic [PAGE_W-1:0] rpage_r, rpage_nxt;
  logic              rwr_r, rwr_nxt;
  logic [PAGE_W-1:0] freed_r, freed_nxt;
  logic              ov_r, ov_nxt;
  logic [STAT_W-1:0] o_st_r, o_st_nxt;
  logic [PAGE_W-1:0] o_page_r, o_page_nxt;
  logic              o_wr_r, o_wr_nxt;
  logic [PAGE_W-1:0] o_freed_r, o_freed_nxt;

  logic              ram_we;
  logic [CW-1:0]     ram_wa;
  rtf_entry_t        ram_wd;
  rtf_entry_t        rd;

  logic              accept;
  logic [END_W-1:0]  s_ext, e_end, page_ext, pg1, len_ext, in_end, room;
  logic              last, gap_ok, tail_ok, fault_hit;

  rtf_ram #(.Depth(MAX_REGIONS), .AddrW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa[AW-1:0]),
    .wdata (ram_wd),
    .raddr (iss_r[AW-1:0]),
    .rdata (rd)
  );

  assign accept   = in_req.valid && in_req.ready;
  assign s_ext    = {1'b0, rd.start};
  assign e_end    = s_ext + {1'b0, rd.length};
  assign page_ext = {1'b0, page_r};
  assign pg1      = page_ext + END_W'(1);
  assign len_ext  = {1'b0, len_r};
  assign in_end   = {1'b0, in_req.page} + {1'b0, in_req.length_pages};
  assign room     = s_ext - prev_end_r;
  assign last     = (ridx_r == cnt_r - ONE);
  assign gap_ok   = (s_ext > prev_end_r) && (room >= len_ext);
  assign tail_ok  = (UEND > e_end) && ((UEND - e_end) >= len_ext);
  assign fault_hit = (prev_end_r <= page_ext) && (page_ext < s_ext);

  assign in_req.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    act_nxt = act_r;
    page_nxt = page_r;
    len_nxt = len_r;
    wr_nxt = wr_r;
    gd_nxt = gd_r;
    cnt_nxt = cnt_r;
    iss_nxt = iss_r;
    rv_nxt = 1'b0;
    ridx_nxt = ridx_r;
    prev_end_nxt = prev_end_r;
    at_nxt = at_r;
    rem_nxt = rem_r;
    dn_nxt = dn_r;
    fin_nxt = fin_r;
    two_nxt = two_r;
    inc_nxt = inc_r;
    dec_nxt = dec_r;
    fa_nxt = fa_r;
    fw0_nxt = fw0_r;
    fw1_nxt = fw1_r;
    st_nxt = st_r;
    rpage_nxt = rpage_r;
    rwr_nxt = rwr_r;
    freed_nxt = freed_r;
    ov_nxt = ov_r && !out_rsp.ready;
    o_st_nxt = o_st_r;
    o_page_nxt = o_page_r;
    o_wr_nxt = o_wr_r;
    o_freed_nxt = o_freed_r;
    ram_we = 1'b0;
    ram_wa = fa_r;
    ram_wd = fw0_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          act_nxt = in_req.action;
          page_nxt = in_req.page;
          len_nxt = in_req.length_pages;
          wr_nxt = in_req.writable;
          gd_nxt = in_req.grows_down;
          st_nxt = ST_OK;
          rpage_nxt = '0;
          rwr_nxt = 1'b0;
          freed_nxt = '0;
          prev_end_nxt = '0;
          iss_nxt = '0;
          at_nxt = in_req.page;
          rem_nxt = '0;
          dn_nxt = 1'b0;
          fin_nxt = 1'b1;
          two_nxt = 1'b0;
          inc_nxt = 1'b1;
          dec_nxt = 1'b0;
          fa_nxt = '0;
          fw0_nxt = '{start: '0, length: in_req.length_pages,
                      wr: in_req.writable, gd: in_req.grows_down};
          state_nxt = S_DONE;
          case (in_req.action)
            ACT_ALLOC: begin
              if (in_req.length_pages == '0 || {1'b0, in_req.length_pages} > UEND) begin
                st_nxt = ST_NOSPACE;
              end else if (cnt_r >= MAXC) begin
                st_nxt = ST_FULL;
              end else if (cnt_r == '0) begin
                state_nxt = S_SHIFT;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            ACT_FIXED: begin
              if (in_req.length_pages == '0 || in_end > UEND) begin
                st_nxt = ST_NOSPACE;
              end else if (cnt_r >= MAXC) begin
                st_nxt = ST_FULL;
              end else if (cnt_r == '0) begin
                fw0_nxt.start = in_req.page;
                state_nxt = S_SHIFT;
              end else begin
                state_nxt = S_POS;
              end
            end
            ACT_REMOVE, ACT_UNMAP: begin
              if (cnt_r == '0) begin
                st_nxt = ST_NOTFOUND;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            ACT_FAULT: begin
              if (cnt_r == '0) begin
                st_nxt = ST_FATAL;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              st_nxt = ST_OK;
            end
          endcase
        end
      end

      S_SCAN, S_POS: begin
        if (iss_r < cnt_r) begin
          rv_nxt = 1'b1;
          ridx_nxt = iss_r;
          iss_nxt = iss_r + ONE;
        end
        if (rv_r) begin
          prev_end_nxt = e_end;
          rem_nxt = '0;
          dn_nxt = 1'b0;
          fin_nxt = 1'b1;
          two_nxt = 1'b0;
          inc_nxt = 1'b0;
          dec_nxt = 1'b0;
          fa_nxt = ridx_r;
          fw0_nxt = rd;
          fw1_nxt = rd;
          if (state_r == S_POS) begin
            if (rd.start > at_r || last) begin
              fa_nxt = (rd.start > at_r) ? ridx_r : cnt_r;
              rem_nxt = cnt_r - ((rd.start > at_r) ? ridx_r : cnt_r);
              iss_nxt = cnt_r - ONE;
              inc_nxt = 1'b1;
              fw0_nxt = '{start: at_r, length: len_r, wr: wr_r, gd: gd_r};
              if (act_r == ACT_ALLOC) begin
                rpage_nxt = at_r;
              end
              rv_nxt = 1'b0;
              state_nxt = S_SHIFT;
            end
          end else begin
            case (act_r)
              ACT_ALLOC: begin
                if (gap_ok || (last && tail_ok)) begin
                  at_nxt = gap_ok ? prev_end_r[PAGE_W-1:0] : e_end[PAGE_W-1:0];
                  iss_nxt = '0;
                  rv_nxt = 1'b0;
                  state_nxt = S_POS;
                end else if (last) begin
                  st_nxt = ST_NOSPACE;
                  state_nxt = S_DONE;
                end
              end
              ACT_REMOVE: begin
                if (rd.start == page_r) begin
                  freed_nxt = rd.length;
                  rem_nxt = cnt_r - ONE - ridx_r;
                  iss_nxt = ridx_r + ONE;
                  dn_nxt = 1'b1;
                  fin_nxt = 1'b0;
                  dec_nxt = 1'b1;
                  rv_nxt = 1'b0;
                  state_nxt = S_SHIFT;
                end else if (last) begin
                  st_nxt = ST_NOTFOUND;
                  state_nxt = S_DONE;
                end
              end
              ACT_UNMAP: begin
                rv_nxt = 1'b0;
                state_nxt = S_SHIFT;
                freed_nxt = PAGE_W'(1);
                if (rd.start == page_r) begin
                  if (rd.length == PAGE_W'(1)) begin
                    rem_nxt = cnt_r - ONE - ridx_r;
                    iss_nxt = ridx_r + ONE;
                    dn_nxt = 1'b1;
                    fin_nxt = 1'b0;
                    dec_nxt = 1'b1;
                  end else begin
                    fw0_nxt.start = rd.start + PAGE_W'(1);
                    fw0_nxt.length = rd.length - PAGE_W'(1);
                  end
                end else if (s_ext < page_ext && pg1 < e_end) begin
                  if (cnt_r >= MAXC) begin
                    freed_nxt = '0;
                    st_nxt = ST_FULL;
                    state_nxt = S_DONE;
                  end else begin
                    rem_nxt = cnt_r - ridx_r - ONE;
                    iss_nxt = cnt_r - ONE;
                    two_nxt = 1'b1;
                    inc_nxt = 1'b1;
                    fw0_nxt.length = page_r - rd.start;
                    fw1_nxt.start = pg1[PAGE_W-1:0];
                    fw1_nxt.length = PAGE_W'(e_end - pg1);
                  end
                end else if (pg1 == e_end) begin
                  fw0_nxt.length = rd.length - PAGE_W'(1);
                end else begin
                  freed_nxt = '0;
                  if (last) begin
                    st_nxt = ST_NOTFOUND;
                    state_nxt = S_DONE;
                  end else begin
                    rv_nxt = (iss_r < cnt_r);
                    state_nxt = S_SCAN;
                  end
                end
              end
              ACT_FAULT: begin
                if (fault_hit) begin
                  rv_nxt = 1'b0;
                  if (room >= END_W'(2) && rd.gd) begin
                    fw0_nxt.start = rd.start - PAGE_W'(1);
                    fw0_nxt.length = rd.length + PAGE_W'(1);
                    rpage_nxt = rd.start - PAGE_W'(1);
                    rwr_nxt = rd.wr;
                    state_nxt = S_SHIFT;
                  end else begin
                    st_nxt = ST_FATAL;
                    state_nxt = S_DONE;
                  end
                end else if (last) begin
                  rv_nxt = 1'b0;
                  st_nxt = ST_FATAL;
                  state_nxt = S_DONE;
                end
              end
              default: begin
                state_nxt = S_DONE;
              end
            endcase
          end
        end
      end

      S_SHIFT: begin
        ram_we = rv_r;
        ram_wa = dn_r ? (ridx_r - ONE) : (ridx_r + ONE);
        ram_wd = rd;
        if (rem_r != '0) begin
          rv_nxt = 1'b1;
          ridx_nxt = iss_r;
          iss_nxt = dn_r ? (iss_r + ONE) : (iss_r - ONE);
          rem_nxt = rem_r - ONE;
        end else if (!rv_r) begin
          if (fin_r) begin
            state_nxt = S_FIN;
          end else begin
            if (dec_r) begin
              cnt_nxt = cnt_r - ONE;
            end
            state_nxt = S_DONE;
          end
        end
      end

      S_FIN: begin
        ram_we = 1'b1;
        if (inc_r) begin
          cnt_nxt = cnt_r + ONE;
        end
        state_nxt = two_r ? S_FIN2 : S_DONE;
      end

      S_FIN2: begin
        ram_we = 1'b1;
        ram_wa = fa_r + ONE;
        ram_wd = fw1_r;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!ov_r || out_rsp.ready) begin
          ov_nxt = 1'b1;
          o_st_nxt = st_r;
          o_page_nxt = rpage_r;
          o_wr_nxt = rwr_r;
          o_freed_nxt = freed_r;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      rv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      rv_r <= rv_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r <= act_nxt;
    page_r <= page_nxt;
    len_r <= len_nxt;
    wr_r <= wr_nxt;
    gd_r <= gd_nxt;
    iss_r <= iss_nxt;
    ridx_r <= ridx_nxt;
    prev_end_r <= prev_end_nxt;
    at_r <= at_nxt;
    rem_r <= rem_nxt;
    dn_r <= dn_nxt;
    fin_r <= fin_nxt;
    two_r <= two_nxt;
    inc_r <= inc_nxt;
    dec_r <= dec_nxt;
    fa_r <= fa_nxt;
    fw0_r <= fw0_nxt;
    fw1_r <= fw1_nxt;
    st_r <= st_nxt;
    rpage_r <= rpage_nxt;
    rwr_r <= rwr_nxt;
    freed_r <= freed_nxt;
    o_st_r <= o_st_nxt;
    o_page_r <= o_page_nxt;
    o_wr_r <= o_wr_nxt;
    o_freed_r <= o_freed_nxt;
  end

  assign out_rsp.valid           = ov_r;
  assign out_rsp.status          = o_st_r;
  assign out_rsp.result_page     = o_page_r;
  assign out_rsp.result_writable = o_wr_r;
  assign out_rsp.freed_pages     = o_freed_r;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAXC) else $error("region count above table depth");

  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != S_IDLE) else $error("request accepted without work");

  a_no_write_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_SCAN || state_r == S_POS) |-> !ram_we)
    else $error("table written during search");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != $past(cnt_r) |-> (cnt_r == $past(cnt_r) + ONE || cnt_r == $past(cnt_r) - ONE))
    else $error("region count jumped");
`endif

endmodule

[sim/tb_region_table_first_fit.sv]
`timescale 1ns / 1ps
module tb_region_table_first_fit;
  import rtf_pkg::*;

  localparam int NREG     = 16;
  localparam int END_PAGE = 786432;
  localparam int LIMIT    = 2000000;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PAGE_W-1:0] rpage;
    logic              rwr;
    logic [PAGE_W-1:0] freed;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #4 clk = ~clk;

  rtf_req_if req_if ();
  rtf_rsp_if rsp_if ();

  region_table_first_fit #(.MAX_REGIONS(NREG), .USER_END_PAGE(END_PAGE)) uut (
    .clk(clk), .rst_n(rst_n), .in_req(req_if.sink), .out_rsp(rsp_if.source)
  );

  rtf_entry_t table_m [NREG];
  int         tab_cnt;
  outcome_t   pending_q [$];
  int         errors;
  int         cycles;

  initial begin
    req_if.valid = 1'b0;
    req_if.action = ACT_ALLOC;
    req_if.page = '0;
    req_if.length_pages = '0;
    req_if.writable = 1'b0;
    req_if.grows_down = 1'b0;
    rsp_if.ready = 1'b0;
    errors = 0;
    cycles = 0;
    tab_cnt = 0;
  end

  function automatic longint end_at(int i);
    return longint'(table_m[i].start) + longint'(table_m[i].length);
  endfunction

  function automatic void shift_up(int pos);
    for (int i = tab_cnt; i > pos; i--) table_m[i] = table_m[i-1];
    tab_cnt++;
  endfunction

  function automatic void shift_down(int pos);
    for (int i = pos; i + 1 < tab_cnt; i++) table_m[i] = table_m[i+1];
    tab_cnt--;
  endfunction

  function automatic void place(longint st, longint ln, logic w, logic g);
    int pos;
    pos = 0;
    while (pos < tab_cnt && table_m[pos].start <= st) pos++;
    shift_up(pos);
    table_m[pos].start = st[PAGE_W-1:0];
    table_m[pos].length = ln[PAGE_W-1:0];
    table_m[pos].wr = w;
    table_m[pos].gd = g;
  endfunction

  function automatic outcome_t apply_action(logic [ACT_W-1:0] act, logic [PAGE_W-1:0] pg,
                                            logic [PAGE_W-1:0] ln, logic w, logic g);
    outcome_t r;
    bit found;
    longint at, s, e, room;
    int cand;
    r = '0;
    r.status = ST_OK;
    case (act)
      ACT_ALLOC: begin
        if (ln == 0 || ln > END_PAGE) r.status = ST_NOSPACE;
        else if (tab_cnt >= NREG) r.status = ST_FULL;
        else begin
          found = 0;
          at = 0;
          if (tab_cnt == 0 || table_m[0].start >= ln) found = 1;
          else begin
            for (int i = 0; i + 1 < tab_cnt && !found; i++)
              if (longint'(table_m[i+1].start) > end_at(i) &&
                  longint'(table_m[i+1].start) - end_at(i) >= ln) begin
                at = end_at(i);
                found = 1;
              end
            if (!found && END_PAGE > end_at(tab_cnt-1) &&
                END_PAGE - end_at(tab_cnt-1) >= ln) begin
              at = end_at(tab_cnt-1);
              found = 1;
            end
          end
          if (found) begin
            place(at, longint'(ln), w, g);
            r.rpage = at[PAGE_W-1:0];
          end else r.status = ST_NOSPACE;
        end
      end
      ACT_FIXED: begin
        if (ln == 0 || longint'(pg) + longint'(ln) > END_PAGE) r.status = ST_NOSPACE;
        else if (tab_cnt >= NREG) r.status = ST_FULL;
        else place(longint'(pg), longint'(ln), w, g);
      end
      ACT_REMOVE: begin
        r.status = ST_NOTFOUND;
        for (int i = 0; i < tab_cnt; i++)
          if (table_m[i].start == pg) begin
            r.freed = table_m[i].length;
            shift_down(i);
            r.status = ST_OK;
            break;
          end
      end
      ACT_UNMAP: begin
        r.status = ST_NOTFOUND;
        for (int i = 0; i < tab_cnt; i++) begin
          s = longint'(table_m[i].start);
          e = end_at(i);
          if (longint'(pg) == s) begin
            table_m[i].start = PAGE_W'(s + 1);
            table_m[i].length--;
          end else if (s < longint'(pg) && longint'(pg) + 1 < e) begin
            if (tab_cnt >= NREG) begin
              r.status = ST_FULL;
              break;
            end
            shift_up(i);
            table_m[i].length = PAGE_W'(longint'(pg) - s);
            table_m[i+1].start = PAGE_W'(longint'(pg) + 1);
            table_m[i+1].length = PAGE_W'(e - (longint'(pg) + 1));
          end else if (longint'(pg) + 1 == e) begin
            table_m[i].length--;
          end else continue;
          if (table_m[i].length == 0) shift_down(i);
          r.status = ST_OK;
          r.freed = PAGE_W'(1);
          break;
        end
      end
      ACT_FAULT: begin
        cand = -1;
        room = 0;
        if (tab_cnt > 0) begin
          if (pg < table_m[0].start) begin
            cand = 0;
            room = longint'(table_m[0].start);
          end else begin
            for (int i = 0; i + 1 < tab_cnt; i++)
              if (end_at(i) <= longint'(pg) && pg < table_m[i+1].start) begin
                cand = i + 1;
                room = longint'(table_m[i+1].start) - end_at(i);
                break;
              end
          end
        end
        if (cand >= 0 && room >= 2 && table_m[cand].gd) begin
          table_m[cand].start--;
          table_m[cand].length++;
          r.rpage = table_m[cand].start;
          r.rwr = table_m[cand].wr;
        end else r.status = ST_FATAL;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pause_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return int'($urandom_range(10, 60));
    return int'($urandom_range(0, 3));
  endfunction

  task automatic send_request(logic [ACT_W-1:0] act, logic [PAGE_W-1:0] pg,
                              logic [PAGE_W-1:0] ln, logic w, logic g);
    int gap;
    gap = pause_len();
    @(posedge clk);
    repeat (gap) @(posedge clk);
    req_if.valid <= 1'b1;
    req_if.action <= act;
    req_if.page <= pg;
    req_if.length_pages <= ln;
    req_if.writable <= w;
    req_if.grows_down <= g;
    do @(posedge clk); while (!req_if.ready);
    pending_q.push_back(apply_action(act, pg, ln, w, g));
    req_if.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready) begin
        outcome_t want;
        outcome_t got;
        got = '{rsp_if.status, rsp_if.result_page, rsp_if.result_writable,
                rsp_if.freed_pages};
        if (pending_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h", got);
        end else begin
          want = pending_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch: expected st=%0d pg=%0d wr=%0d fr=%0d,",
                        " got st=%0d pg=%0d wr=%0d fr=%0d"},
                       want.status, want.rpage, want.rwr, want.freed,
                       got.status, got.rpage, got.rwr, got.freed);
          end
        end
      end
      rsp_if.ready <= ($urandom_range(0, 3) != 0) ||
                      ($urandom_range(0, 1) == 0 && !rsp_if.ready);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [PAGE_W-1:0] known_start();
    if (tab_cnt == 0) return PAGE_W'($urandom_range(0, END_PAGE - 1));
    return table_m[$urandom_range(0, tab_cnt - 1)].start;
  endfunction

  function automatic logic [PAGE_W-1:0] near_page();
    int i;
    longint p;
    if (tab_cnt == 0) return PAGE_W'($urandom_range(0, END_PAGE - 1));
    i = int'($urandom_range(0, tab_cnt - 1));
    p = longint'(table_m[i].start) + longint'($urandom_range(0, 4)) - 2;
    if ($urandom_range(0, 1)) p = end_at(i) + longint'($urandom_range(0, 3)) - 2;
    if (p < 0) p = 0;
    return p[PAGE_W-1:0];
  endfunction

  task automatic test_directed();
    send_request(ACT_FAULT, 20'd5, 20'd0, 1'b0, 1'b0);
    send_request(ACT_REMOVE, 20'd0, 20'd0, 1'b0, 1'b0);
    send_request(ACT_UNMAP, 20'd0, 20'd0, 1'b0, 1'b0);
    send_request(ACT_ALLOC, 20'd0, 20'd0, 1'b1, 1'b1);
    send_request(ACT_ALLOC, 20'd0, 20'd786433, 1'b1, 1'b1);
    send_request(ACT_ALLOC, 20'hFFFFF, 20'hFFFFF, 1'b1, 1'b1);
    send_request(ACT_FIXED, 20'd786431, 20'd2, 1'b0, 1'b0);
    send_request(ACT_FIXED, 20'd786431, 20'd1, 1'b1, 1'b0);
    send_request(ACT_FIXED, 20'd100, 20'd10, 1'b1, 1'b1);
    send_request(ACT_FIXED, 20'd100, 20'd5, 1'b0, 1'b1);
    send_request(ACT_ALLOC, 20'd0, 20'd50, 1'b1, 1'b0);
    send_request(ACT_ALLOC, 20'd0, 20'd60, 1'b0, 1'b0);
    send_request(ACT_FAULT, 20'd98, 20'd0, 1'b0, 1'b0);
    send_request(ACT_FAULT, 20'd99, 20'd0, 1'b0, 1'b0);
    send_request(ACT_FAULT, 20'd103, 20'd0, 1'b0, 1'b0);
    send_request(ACT_FAULT, 20'd786431, 20'd0, 1'b0, 1'b0);
    send_request(ACT_UNMAP, 20'd99, 20'd0, 1'b0, 1'b0);
    send_request(ACT_UNMAP, 20'd104, 20'd0, 1'b0, 1'b0);
    send_request(ACT_UNMAP, 20'd109, 20'd0, 1'b0, 1'b0);
    send_request(ACT_UNMAP, 20'd786431, 20'd0, 1'b0, 1'b0);
    send_request(ACT_REMOVE, known_start(), 20'd0, 1'b0, 1'b0);
    send_request(3'd7, 20'hFFFFF, 20'hFFFFF, 1'b1, 1'b1);
    drain();
  endtask

  task automatic test_full_table();
    for (int i = 0; i < NREG + 2; i++)
      send_request(ACT_ALLOC, 20'd0, PAGE_W'($urandom_range(1, 3)), i[0], i[1]);
    send_request(ACT_FIXED, 20'd500000, 20'd1, 1'b0, 1'b0);
    send_request(ACT_UNMAP, table_m[0].start + 20'd1, 20'd0, 1'b0, 1'b0);
    send_request(ACT_FAULT, 20'd700000, 20'd0, 1'b0, 1'b0);
    while (tab_cnt > 0) send_request(ACT_REMOVE, table_m[tab_cnt-1].start, 20'd0, 1'b0, 1'b0);
    drain();
  endtask

  task automatic test_random(int n);
    logic [ACT_W-1:0] act;
    logic [PAGE_W-1:0] pg, ln;
    int sel;
    for (int k = 0; k < n; k++) begin
      sel = int'($urandom_range(0, 99));
      if (sel < 25) act = ACT_ALLOC;
      else if (sel < 40) act = ACT_FIXED;
      else if (sel < 55) act = ACT_REMOVE;
      else if (sel < 75) act = ACT_UNMAP;
      else if (sel < 97) act = ACT_FAULT;
      else act = 3'($urandom_range(5, 7));
      case ($urandom_range(0, 9))
        0: ln = PAGE_W'($urandom());
        1: ln = PAGE_W'($urandom_range(1000, 200000));
        default: ln = PAGE_W'($urandom_range(0, 40));
      endcase
      case ($urandom_range(0, 9))
        0: pg = PAGE_W'($urandom());
        1, 2: pg = PAGE_W'($urandom_range(0, END_PAGE - 1));
        3, 4: pg = known_start();
        default: pg = near_page();
      endcase
      if (act == ACT_FAULT && tab_cnt > 0 && $urandom_range(0, 1))
        pg = table_m[$urandom_range(0, tab_cnt - 1)].start - PAGE_W'($urandom_range(1, 4));
      if (tab_cnt > 12 && act == ACT_ALLOC && $urandom_range(0, 1)) begin
        act = ACT_REMOVE;
        pg = known_start();
      end
      send_request(act, pg, ln, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      if (k == n / 2) drain();
    end
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_random(800);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
